### hdl/itda_pkg.sv
// ----------------------------------------------------------------------------
// Integer to decimal ASCII: shared package
// Widths, character codes, the queue entry type and the table of digit
// multiples used by the conversion engine.
// ----------------------------------------------------------------------------
`default_nettype none

package itda_pkg;

  // Width of the integer that is converted.
  localparam int VALUE_BITS = 32;
  // Width of the input and result ports.
  localparam int IN_W   = 32;
  localparam int CHAR_W = 8;

  // Number of decimal digits of the largest magnitude, 2**VALUE_BITS - 1.
  function automatic int count_digits();
    logic [127:0] v;
    int           n;
    v = (128'd1 << VALUE_BITS) - 128'd1;
    n = 0;
    while (v != 128'd0) begin
      v = v / 128'd10;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int NUM_DIGITS = count_digits();
  localparam int POS_W      = $clog2(NUM_DIGITS);
  // Nine times the top power of ten stays below 16 * 2**VALUE_BITS.
  localparam int MULT_W     = VALUE_BITS + 4;
  localparam int DIGIT_W    = 4;
  localparam int NUM_MULTS  = 9;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_TREAT_AS_SIGNED = '0;

  // Queue depth between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } item_t;

  // Row k holds d * 10**k for d = 1 .. 9.
  typedef logic [NUM_MULTS-1:0][MULT_W-1:0] mult_row_t;
  typedef mult_row_t [NUM_DIGITS-1:0]       mult_tab_t;

  function automatic mult_tab_t build_mult_tab();
    mult_tab_t         t;
    logic [MULT_W-1:0] p;
    p = MULT_W'(1);
    for (int k = 0; k < NUM_DIGITS; k++) begin
      for (int d = 0; d < NUM_MULTS; d++) begin
        t[k][d] = p * MULT_W'(d + 1);
      end
      p = p * MULT_W'(10);
    end
    return t;
  endfunction

  localparam mult_tab_t MULT_TAB = build_mult_tab();

endpackage

`default_nettype wire

### hdl/integer_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// Integer to decimal ASCII converter
// Turns a 32-bit integer into its decimal text, one ASCII character per
// result, with the final character marked.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                 Handshake
//   -------   -----------------------------------   --------------------------
//   input     start, busy, in_value_bits            taken when start & !busy
//   result    out_valid, out_character,             one-cycle strobe, no stall
//             out_last_char
//   config    psel, penable, pwrite, paddr,         APB, pready tied high
//             pwdata, prdata, pready
//
// Each request holds the conversion engine for one sign slot followed by one
// step for each of the ten powers of ten, from 10**9 down to 10**0. That
// per-digit step through the engine sets the sustained rate; a request that
// finds the engine idle is first taken from the queue in the idle state,
// while one waiting at the final digit goes straight to the sign slot.
// A request enters the two-entry queue in the cycle it is taken, so up to two
// further requests may be accepted while one is being converted; busy is
// raised only when the queue is full.
// Into an empty block, a request passes through the queue and the sign slot
// before a minus sign appears on the registered output; suppressed leading
// zeros leave cycles with no strobe. The receiver cannot hold results off.
// Reset is synchronous and active low; it empties the queue, idles the engine
// and sets treat_as_signed to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_decimal_ascii_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input requests.
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [itda_pkg::IN_W-1:0]       in_value_bits,
  // Results.
  output logic                                 out_valid,
  output logic [itda_pkg::CHAR_W-1:0]          out_character,
  output logic                                 out_last_char,
  // Configuration.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [itda_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [itda_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [itda_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import itda_pkg::*;

  logic  treat_as_signed_r, treat_as_signed_nxt;
  logic  cfg_write;
  logic  sel_signed_reg;

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  item_t q_push_item;
  item_t q_head_item;

  // The register map is word aligned; only the first word is populated.
  // Writes to any other word are dropped and read back as zero.
  assign pready         = 1'b1;
  assign sel_signed_reg = (paddr[CFG_ADDR_W-1:2] == REG_TREAT_AS_SIGNED);
  assign cfg_write      = psel & penable & pwrite & pready;

  always_comb begin
    treat_as_signed_nxt = treat_as_signed_r;
    if (cfg_write && sel_signed_reg) begin
      treat_as_signed_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      treat_as_signed_r <= 1'b1;
    end else begin
      treat_as_signed_r <= treat_as_signed_nxt;
    end
  end

  assign prdata = sel_signed_reg ? {{(CFG_DATA_W-1){1'b0}}, treat_as_signed_r} : '0;

  // The front end classifies each request and places it in the queue.
  itda_front u_front (
    .start           (start),
    .in_value_bits   (in_value_bits),
    .treat_as_signed (treat_as_signed_r),
    .q_full          (q_full),
    .busy            (busy),
    .push            (q_push),
    .push_item       (q_push_item)
  );

  itda_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .head_item (q_head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  // The engine drains the queue, one request at a time.
  itda_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_item     (q_head_item),
    .q_empty       (q_empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

endmodule

`default_nettype wire

### hdl/itda_front.sv
// ----------------------------------------------------------------------------
// Integer to decimal ASCII: front end
// Accepts a request, decides its sign and forms its unsigned magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module itda_front (
  input  wire logic                      start,
  input  wire logic [itda_pkg::IN_W-1:0] in_value_bits,
  input  wire logic                      treat_as_signed,
  input  wire logic                      q_full,
  output logic                           busy,
  output logic                           push,
  output itda_pkg::item_t                push_item
);
  import itda_pkg::*;

  logic [VALUE_BITS-1:0] x;
  logic                  neg;

  assign x    = in_value_bits[VALUE_BITS-1:0];
  assign neg  = treat_as_signed & x[VALUE_BITS-1];
  assign busy = q_full;
  assign push = start & ~q_full;

  // The two's complement of the most negative value is its own magnitude
  // when read as unsigned, so no overflow can occur here.
  always_comb begin
    push_item.neg = neg;
    push_item.mag = neg ? (~x + VALUE_BITS'(1)) : x;
  end

endmodule

`default_nettype wire

### hdl/itda_queue.sv
// ----------------------------------------------------------------------------
// Integer to decimal ASCII: request queue
// A short first-in first-out queue between the front end and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module itda_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire itda_pkg::item_t push_item,
  input  wire logic            pop,
  output itda_pkg::item_t      head_item,
  output logic                 full,
  output logic                 empty
);
  import itda_pkg::*;

  item_t                entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty     = (count_r == '0);
  assign head_item = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    count_nxt = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

### hdl/itda_back.sv
// ----------------------------------------------------------------------------
// Integer to decimal ASCII: conversion engine
// Emits the sign slot, then one decimal digit per cycle from the highest
// power of ten down, suppressing leading zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module itda_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire itda_pkg::item_t             head_item,
  input  wire logic                        q_empty,
  output logic                             pop,
  output logic                             out_valid,
  output logic [itda_pkg::CHAR_W-1:0]      out_character,
  output logic                             out_last_char
);
  import itda_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SIGN  = 3'b010,
    ST_DIGIT = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic                  neg_r, neg_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  started_r, started_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  mult_row_t             row;
  logic [NUM_MULTS-1:0]  ge;
  logic [DIGIT_W-1:0]    digit;
  logic [MULT_W-1:0]     sub;
  logic                  emit;

  // Digit at the current power: how many of its nine multiples fit.
  always_comb begin
    row   = MULT_TAB[pos_r];
    digit = '0;
    sub   = '0;
    for (int d = 0; d < NUM_MULTS; d++) begin
      ge[d] = ({4'b0, mag_r} >= row[d]);
      digit = digit + DIGIT_W'(ge[d]);
      if (ge[d]) begin
        sub = row[d];
      end
    end
    emit = started_r | (digit != '0) | (pos_r == '0);
  end

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    pos_nxt       = pos_r;
    started_nxt   = started_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          neg_nxt   = head_item.neg;
          mag_nxt   = head_item.mag;
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        out_valid_nxt = neg_r;
        out_char_nxt  = CH_MINUS;
        out_last_nxt  = 1'b0;
        pos_nxt       = POS_W'(NUM_DIGITS - 1);
        started_nxt   = 1'b0;
        state_nxt     = ST_DIGIT;
      end
      ST_DIGIT: begin
        out_valid_nxt = emit;
        out_char_nxt  = CH_ZERO + CHAR_W'(digit);
        out_last_nxt  = (pos_r == '0);
        mag_nxt       = mag_r - sub[VALUE_BITS-1:0];
        started_nxt   = emit;
        if (pos_r == '0) begin
          if (!q_empty) begin
            pop       = 1'b1;
            neg_nxt   = head_item.neg;
            mag_nxt   = head_item.mag;
            state_nxt = ST_SIGN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          pos_nxt = pos_r - POS_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    pos_r      <= pos_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last_char = out_last_r;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGIT) |-> (pos_r < POS_W'(NUM_DIGITS)))
    else $error("digit position out of range");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_char_r == CH_MINUS)) |-> !out_last_r)
    else $error("sign character marked as last");

  a_last_ends_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (state_r != ST_DIGIT))
    else $error("engine still in digit phase after final character");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_empty)
    else $error("pop from empty queue");

  a_sign_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == ST_SIGN))
    else $error("request taken without entering sign slot");
`endif

endmodule

`default_nettype wire
